FILE: rtl/core/gis_pkg.sv
package gis_pkg;

	localparam int VALUE_W        = 32;
	localparam int GROUP_W        = 8;
	localparam int GROUP_SPAN     = 1 << GROUP_W;
	localparam int NUM_GROUPS_DEF = 256;
	localparam int MODE_W         = 2;

	localparam logic [VALUE_W-1:0] MISSING_MARK = {1'b1, {(VALUE_W-1){1'b0}}};

	localparam logic [MODE_W-1:0] NA_PROPAGATE = 2'd0;
	localparam logic [MODE_W-1:0] NA_ZERO      = 2'd1;
	localparam logic [MODE_W-1:0] NA_SKIP      = 2'd2;
	localparam logic [MODE_W-1:0] NA_SKIP_ALT  = 2'd3;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [GROUP_W-1:0]        group;
		logic                      series_start;
	} in_beat_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] sum;
		logic                      overflow;
	} out_beat_t;

endpackage

FILE: rtl/core/gis_ram.sv
module gis_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: rtl/core/grouped_int_running_sum.sv
// Grouped running sum over a stream of signed 32-bit samples.
// Input channel (in_valid/in_ready/in_data): one beat per sample, carrying the
// value, its group index and a series-start mark that clears all group sums
// before the sample is used. Output channel (out_valid/out_ready/out_data): one
// beat per sample with the group's updated sum (missing mark if skipped) and an
// overflow flag. Configuration: cfg_wr_en/cfg_wr_data write the missing-value
// mode; write it only while no beat is in flight.
// An accepted sample goes into the compute stage, then the output register.
// Throughput: one sample per cycle while out_ready is high. The per-group sums
// sit in a one-port-read, one-port-write RAM with a registered read; a write to
// the same group in the cycle before is forwarded around the RAM, so no sample
// ever waits on another. Group liveness is kept in flops, so a series start
// clears everything at once. Reset: all sums read as zero and the mode returns
// to propagate; no clearing pass is needed. When the receiver stalls, the output
// register holds its beat and one more sample can still be accepted into the
// compute stage; in_ready drops only while both are full.
module grouped_int_running_sum import gis_pkg::*; #(
	parameter int NUM_GROUPS = NUM_GROUPS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [MODE_W-1:0] cfg_wr_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_beat_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_beat_t         out_data
);

	localparam int DEPTH = (NUM_GROUPS < GROUP_SPAN) ? NUM_GROUPS : GROUP_SPAN;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [MODE_W-1:0]  na_mode_q;
	logic               v_s1;
	logic [AW-1:0]      g_s1;
	logic [VALUE_W-1:0] value_s1;
	logic               byp_vld_s1;
	logic [VALUE_W-1:0] byp_data_s1;
	logic [DEPTH-1:0]   live_q;
	logic               out_v_q;
	out_beat_t          out_q;

	logic               in_acc;
	logic               s1_go;
	logic [AW-1:0]      in_grp;
	logic [AW-1:0]      rd_addr;
	logic [VALUE_W-1:0] rd_data;
	logic               wr_en;
	logic [VALUE_W-1:0] old_sum;
	logic [VALUE_W-1:0] res;
	logic               flag;
	logic               do_write;
	logic               missing;
	logic               skip_mode;
	logic [VALUE_W:0]   total;

	assign s1_go    = v_s1 && (!out_v_q || out_ready);
	assign in_ready = !v_s1 || s1_go;
	assign in_acc   = in_valid && in_ready;

	assign in_grp  = (32'(in_data.group) >= DEPTH) ? AW'(DEPTH - 1) : AW'(in_data.group);
	assign rd_addr = in_acc ? in_grp : g_s1;

	gis_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(DEPTH)
	) u_sum_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(g_s1),
		.wr_data(res),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		missing   = (value_s1 == MISSING_MARK);
		skip_mode = (na_mode_q == NA_SKIP) || (na_mode_q == NA_SKIP_ALT);
		if (live_q[g_s1]) begin
			old_sum = byp_vld_s1 ? byp_data_s1 : rd_data;
		end else begin
			old_sum = '0;
		end
		total    = {old_sum[VALUE_W-1], old_sum}
		         + (missing ? '0 : {value_s1[VALUE_W-1], value_s1});
		res      = MISSING_MARK;
		flag     = 1'b0;
		do_write = 1'b0;
		if (na_mode_q == NA_PROPAGATE && missing) begin
			do_write = 1'b1;
		end else if (na_mode_q == NA_PROPAGATE && old_sum == MISSING_MARK) begin
			do_write = 1'b0;
		end else if (skip_mode && missing) begin
			do_write = 1'b0;
		end else begin
			res      = total[VALUE_W-1:0];
			flag     = (total[VALUE_W] ^ total[VALUE_W-1])
			         || (total == {1'b1, MISSING_MARK});
			do_write = 1'b1;
		end
	end

	assign wr_en = s1_go && do_write;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			na_mode_q  <= NA_PROPAGATE;
			v_s1       <= 1'b0;
			byp_vld_s1 <= 1'b0;
			live_q     <= '0;
			out_v_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				na_mode_q <= cfg_wr_data;
			end
			if (in_acc) begin
				v_s1 <= 1'b1;
			end else if (s1_go) begin
				v_s1 <= 1'b0;
			end
			byp_vld_s1 <= wr_en && (g_s1 == rd_addr);
			if (in_acc && in_data.series_start) begin
				live_q <= '0;
			end else if (wr_en) begin
				live_q[g_s1] <= 1'b1;
			end
			if (s1_go) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			g_s1     <= in_grp;
			value_s1 <= in_data.value;
		end
		byp_data_s1 <= res;
		if (s1_go) begin
			out_q.sum      <= res;
			out_q.overflow <= flag;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

endmodule

FILE: rtl/core/gis_checker.sv
module gis_props import gis_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input out_beat_t         out_data
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	// an accepted sample is followed by a valid output beat
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##2 out_valid)
		else $error("no result two cycles after accepted beat");

	// input only backs up behind a stalled output
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled with output free");

endmodule

bind grouped_int_running_sum gis_props u_gis_props (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.out_data   (out_data)
);
